@@ hw/rtl/segment_wait_window_tuner_assert.svh @@
// Assertion macros used by the segment wait window tuner checker.
`ifndef SEGMENT_WAIT_WINDOW_TUNER_ASSERT_SVH
`define SEGMENT_WAIT_WINDOW_TUNER_ASSERT_SVH

// Condition and consequence in the same cycle.
`define SWWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define SWWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/swwt_pkg.sv @@
// Shared constants, codes and types of the segment wait window tuner.
`timescale 1ns / 1ps
`default_nettype none

package swwt_pkg;

    // Table sizes.
    localparam int SEGMENTS   = 256;
    localparam int NEST_DEPTH = 30;

    localparam int SEG_IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int NEST_IDX_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int NEST_CNT_W = $clog2(NEST_DEPTH + 1);

    // Field widths.
    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int TIME_W   = 64;
    localparam int STATUS_W = 2;
    localparam int WAIT_W   = 32;
    localparam int NEST_W   = ID_W + 1;

    // Configuration port.
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = 3;

    // Register reset values.
    localparam logic [WAIT_W-1:0] MIN_WAIT_RST     = 32'd1000;
    localparam logic [WAIT_W-1:0] DEFAULT_WAIT_RST = 32'd100000;
    localparam logic [WAIT_W-1:0] MIN_STEP_RST     = 32'd10;
    localparam logic [WAIT_W-1:0] DEFAULT_STEP_RST = 32'd1000;
    localparam logic [TIME_W-1:0] LAT_THRESH_RST   = 64'd0;

    // Step after a decrease is the halved window divided by this constant,
    // done as a multiply by a scaled reciprocal and one correction.
    localparam int DIV_CONST   = 99;
    localparam int HALF_W      = WAIT_W - 1;
    localparam int RECIP_SHIFT = 38;
    localparam int RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / DIV_CONST);
    localparam int PROD_W = HALF_W + RECIP_W;
    localparam int QUO_W  = PROD_W - RECIP_SHIFT;

    typedef enum logic [MODE_W-1:0] {
        MODE_START = 2'd0,
        MODE_END   = 2'd1,
        MODE_MARK  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_INVALID = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_WAIT     = 3'd0,
        REG_DEFAULT_WAIT = 3'd1,
        REG_MIN_STEP     = 3'd2,
        REG_DEFAULT_STEP = 3'd3,
        REG_LAT_THRESH   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TUNE,
        S_FIX,
        S_READ,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/swwt_if.sv @@
// Event and result channel interfaces of the segment wait window tuner.
`timescale 1ns / 1ps
`default_nettype none

interface swwt_cmd_if;
    import swwt_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ID_W-1:0]     seg_sel;
    logic [TIME_W-1:0]   timestamp;
    logic [TIME_W-1:0]   lat_target;

    modport source (
        output valid, mode, seg_sel, timestamp, lat_target,
        input  ready
    );

    modport sink (
        input  valid, mode, seg_sel, timestamp, lat_target,
        output ready
    );
endinterface

interface swwt_rsp_if;
    import swwt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                has_current;
    logic [ID_W-1:0]     current_segment;
    logic [WAIT_W-1:0]   current_wait;

    modport source (
        output valid, status, has_current, current_segment, current_wait,
        input  ready
    );

    modport sink (
        input  valid, status, has_current, current_segment, current_wait,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/segment_wait_window_tuner.sv @@
// Segment wait window tuner top level. Each event beat on cmd (start a
// segment, end it, or mark a waiter on the open one) yields one result beat
// on rsp with the status and the window of the segment open afterwards.
// One event is taken at a time: a start, a mark, an end without tuning, an
// end that snaps the window to its minimum or a rejected event passes
// through the execute, read and response states, an end that grows the
// window adds a tune state, and an end that halves it adds a tune and a
// fix state, since the new step comes from a reciprocal multiply followed
// by a correction. The window/step table and the start time table are
// memories with registered reads. A finished result sits in an output
// register, and the next event is accepted while it waits. Configuration
// is to be written over the APB port only while idle, which the block does
// not enforce; register i lies at byte address 8*i.
`timescale 1ns / 1ps
`default_nettype none

module segment_wait_window_tuner (
    input  logic                              clk,
    input  logic                              rst_n,
    swwt_cmd_if.sink                          cmd,
    swwt_rsp_if.source                        rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swwt_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [swwt_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [swwt_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import swwt_pkg::*;

    // Configuration registers.
    logic [WAIT_W-1:0] min_wait_reg;
    logic [WAIT_W-1:0] default_wait_reg;
    logic [WAIT_W-1:0] min_step_reg;
    logic [WAIT_W-1:0] default_step_reg;
    logic [TIME_W-1:0] lat_thresh_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // Sequencer and segment state.
    state_t                state_reg, state_next;
    logic                  open_valid_reg, open_valid_next;
    logic [ID_W-1:0]       open_id_reg, open_id_next;
    logic [NEST_CNT_W-1:0] nest_count_reg, nest_count_next;
    logic [NEST_W-1:0]     nest_stack_reg [NEST_DEPTH];
    logic [SEGMENTS-1:0]   waiter_reg;
    logic [SEGMENTS-1:0]   tuned_reg;

    // Captured event.
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [TIME_W-1:0] ts_reg, ts_next;
    logic [TIME_W-1:0] req_reg, req_next;

    // Working registers of the tuning unit.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [WAIT_W-1:0]   win_reg, win_next;
    logic [WAIT_W-1:0]   step_reg, step_next;
    logic [TIME_W-1:0]   dur_reg, dur_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    // Table memories.
    logic [2*WAIT_W-1:0] entry_mem [SEGMENTS];
    logic [TIME_W-1:0]   start_mem [SEGMENTS];
    logic [2*WAIT_W-1:0] entry_rd_reg;
    logic [TIME_W-1:0]   start_rd_reg;
    logic                entry_we;
    logic [2*WAIT_W-1:0] entry_wd;
    logic                start_we;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_has_reg;
    logic [ID_W-1:0]     out_seg_reg;
    logic [WAIT_W-1:0]   out_wait_reg;
    logic                out_load;

    // Control strobes and derived values.
    logic                  push;
    logic                  do_pop;
    logic                  waiter_set;
    logic                  waiter_clr;
    logic [SEG_IDX_W-1:0]  cur_idx;
    logic [SEG_IDX_W-1:0]  id_idx;
    logic [NEST_IDX_W-1:0] push_idx;
    logic [NEST_IDX_W-1:0] top_idx;
    logic                  cur_ok;
    logic                  id_ok;
    logic [WAIT_W-1:0]     cur_win;
    logic [WAIT_W-1:0]     cur_step;
    logic [WAIT_W:0]       grow_sum;
    logic [WAIT_W-1:0]     grow_sat;
    logic [WAIT_W-1:0]     grow_win;
    logic [QUO_W-1:0]      quo_raw;
    logic [HALF_W-1:0]     quo_ext;
    logic [HALF_W-1:0]     quo_mul;
    logic [HALF_W-1:0]     quo_rem;
    logic [HALF_W-1:0]     quo_fix;
    logic [WAIT_W-1:0]     shrink_step;
    logic [WAIT_W-1:0]     shrink_win;

    // APB register file: writes complete in the access phase.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[CFG_IDX_LSB +: CFG_IDX_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_wait_reg     <= MIN_WAIT_RST;
            default_wait_reg <= DEFAULT_WAIT_RST;
            min_step_reg     <= MIN_STEP_RST;
            default_step_reg <= DEFAULT_STEP_RST;
            lat_thresh_reg   <= LAT_THRESH_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MIN_WAIT:     min_wait_reg     <= pwdata[WAIT_W-1:0];
                REG_DEFAULT_WAIT: default_wait_reg <= pwdata[WAIT_W-1:0];
                REG_MIN_STEP:     min_step_reg     <= pwdata[WAIT_W-1:0];
                REG_DEFAULT_STEP: default_step_reg <= pwdata[WAIT_W-1:0];
                REG_LAT_THRESH:   lat_thresh_reg   <= pwdata;
                default:          ;
            endcase
        end
    end

    // Register readback.
    always_comb
    begin
        case (cfg_idx)
            REG_MIN_WAIT:     prdata = CFG_DATA_W'(min_wait_reg);
            REG_DEFAULT_WAIT: prdata = CFG_DATA_W'(default_wait_reg);
            REG_MIN_STEP:     prdata = CFG_DATA_W'(min_step_reg);
            REG_DEFAULT_STEP: prdata = CFG_DATA_W'(default_step_reg);
            REG_LAT_THRESH:   prdata = lat_thresh_reg;
            default:          prdata = '0;
        endcase
    end

    // Indexes and range checks of the open segment and the named segment.
    assign cur_idx  = SEG_IDX_W'(open_id_reg);
    assign id_idx   = SEG_IDX_W'(id_reg);
    assign push_idx = NEST_IDX_W'(nest_count_reg);
    assign top_idx  = NEST_IDX_W'(nest_count_reg - NEST_CNT_W'(1));
    assign cur_ok   = open_valid_reg && (32'(open_id_reg) < 32'(SEGMENTS));
    assign id_ok    = 32'(id_reg) < 32'(SEGMENTS);

    // An entry never tuned reads as the configured defaults.
    assign cur_win  = tuned_reg[cur_idx] ? entry_rd_reg[2*WAIT_W-1:WAIT_W]
                                         : default_wait_reg;
    assign cur_step = tuned_reg[cur_idx] ? entry_rd_reg[WAIT_W-1:0]
                                         : default_step_reg;

    // Growth path: add the step with saturation, then floor at min_wait.
    assign grow_sum = {1'b0, win_reg} + {1'b0, step_reg};
    assign grow_sat = grow_sum[WAIT_W] ? '1 : grow_sum[WAIT_W-1:0];
    assign grow_win = (grow_sat < min_wait_reg) ? min_wait_reg : grow_sat;

    // Decrease path: the reciprocal product undershoots the quotient by at
    // most one, so one remainder compare fixes it.
    assign quo_raw     = prod_reg[RECIP_SHIFT +: QUO_W];
    assign quo_ext     = HALF_W'(quo_raw);
    assign quo_mul     = quo_ext * HALF_W'(DIV_CONST);
    assign quo_rem     = win_reg[HALF_W-1:0] - quo_mul;
    assign quo_fix     = quo_ext + HALF_W'(quo_rem >= HALF_W'(DIV_CONST));
    assign shrink_step = (WAIT_W'(quo_fix) < min_step_reg) ? min_step_reg
                                                           : WAIT_W'(quo_fix);
    assign shrink_win  = (win_reg < min_wait_reg) ? min_wait_reg : win_reg;

    // Sequencer: next state, strobes and working register updates.
    always_comb
    begin
        state_next      = state_reg;
        open_valid_next = open_valid_reg;
        open_id_next    = open_id_reg;
        nest_count_next = nest_count_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        ts_next         = ts_reg;
        req_next        = req_reg;
        status_next     = status_reg;
        win_next        = win_reg;
        step_next       = step_reg;
        dur_next        = dur_reg;
        prod_next       = prod_reg;
        push            = 1'b0;
        do_pop          = 1'b0;
        entry_we        = 1'b0;
        entry_wd        = {win_reg, step_reg};
        start_we        = 1'b0;
        waiter_set      = 1'b0;
        waiter_clr      = 1'b0;
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next  = cmd.mode;
                    id_next    = cmd.seg_sel;
                    ts_next    = cmd.timestamp;
                    req_next   = cmd.lat_target;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next = STAT_INVALID;
                state_next  = S_READ;
                case (mode_t'(mode_reg))
                    MODE_START:
                    begin
                        if (id_ok)
                        begin
                            if (nest_count_reg >= NEST_CNT_W'(NEST_DEPTH))
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                push            = 1'b1;
                                start_we        = 1'b1;
                                nest_count_next = nest_count_reg + NEST_CNT_W'(1);
                                open_valid_next = 1'b1;
                                open_id_next    = id_reg;
                                status_next     = STAT_OK;
                            end
                        end
                    end

                    MODE_END:
                    begin
                        if (cur_ok)
                        begin
                            if (!waiter_reg[cur_idx])
                            begin
                                do_pop      = 1'b1;
                                status_next = STAT_OK;
                            end
                            else if (req_reg < lat_thresh_reg)
                            begin
                                // Snap to the minimum; the waiter mark stays.
                                entry_we    = 1'b1;
                                entry_wd    = {min_wait_reg, cur_step};
                                do_pop      = 1'b1;
                                status_next = STAT_OK;
                            end
                            else if (id_ok && (id_reg == open_id_reg))
                            begin
                                dur_next    = ts_reg - start_rd_reg;
                                win_next    = cur_win;
                                step_next   = cur_step;
                                status_next = STAT_OK;
                                state_next  = S_TUNE;
                            end
                        end
                    end

                    MODE_MARK:
                    begin
                        if (cur_ok)
                        begin
                            waiter_set  = 1'b1;
                            status_next = STAT_OK;
                        end
                    end

                    default:
                    begin
                        status_next = STAT_INVALID;
                    end
                endcase
            end

            S_TUNE:
            begin
                if (dur_reg > req_reg)
                begin
                    win_next   = {1'b0, win_reg[WAIT_W-1:1]};
                    prod_next  = PROD_W'(win_reg[WAIT_W-1:1]) * PROD_W'(RECIP);
                    state_next = S_FIX;
                end
                else
                begin
                    entry_we   = 1'b1;
                    entry_wd   = {grow_win, step_reg};
                    waiter_clr = 1'b1;
                    do_pop     = 1'b1;
                    state_next = S_READ;
                end
            end

            S_FIX:
            begin
                entry_we   = 1'b1;
                entry_wd   = {shrink_win, shrink_step};
                waiter_clr = 1'b1;
                do_pop     = 1'b1;
                state_next = S_READ;
            end

            S_READ:
            begin
                // Table read of the segment now open lands at the next edge.
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Reopen the enclosing segment, or none when the stack is empty.
        if (do_pop)
        begin
            if (nest_count_reg == '0)
            begin
                open_valid_next = 1'b0;
                open_id_next    = '0;
            end
            else
            begin
                nest_count_next = nest_count_reg - NEST_CNT_W'(1);
                open_valid_next = nest_stack_reg[top_idx][NEST_W-1];
                open_id_next    = nest_stack_reg[top_idx][ID_W-1:0];
            end
        end
    end

    // Output beat holds until taken.
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            open_valid_reg <= 1'b0;
            open_id_reg    <= '0;
            nest_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            waiter_reg     <= '0;
            tuned_reg      <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            open_valid_reg <= open_valid_next;
            open_id_reg    <= open_id_next;
            nest_count_reg <= nest_count_next;
            out_valid_reg  <= out_valid_next;
            if (waiter_set)
            begin
                waiter_reg[cur_idx] <= 1'b1;
            end
            if (waiter_clr)
            begin
                waiter_reg[cur_idx] <= 1'b0;
            end
            if (entry_we)
            begin
                tuned_reg[cur_idx] <= 1'b1;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        id_reg     <= id_next;
        ts_reg     <= ts_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        win_reg    <= win_next;
        step_reg   <= step_next;
        dur_reg    <= dur_next;
        prod_reg   <= prod_next;
        if (push)
        begin
            nest_stack_reg[push_idx] <= {open_valid_reg, open_id_reg};
        end
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_has_reg    <= cur_ok;
            out_seg_reg    <= cur_ok ? open_id_reg : '0;
            out_wait_reg   <= cur_ok ? cur_win : '0;
        end
    end

    // Window/step table, read every cycle at the open segment.
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            entry_mem[cur_idx] <= entry_wd;
        end
        entry_rd_reg <= entry_mem[cur_idx];
    end

    // Start time table, written by start events.
    always_ff @(posedge clk)
    begin
        if (start_we)
        begin
            start_mem[id_idx] <= ts_reg;
        end
        start_rd_reg <= start_mem[cur_idx];
    end

    // Channel outputs.
    assign cmd.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.has_current     = out_has_reg;
    assign rsp.current_segment = out_seg_reg;
    assign rsp.current_wait    = out_wait_reg;

endmodule

`default_nettype wire

@@ hw/rtl/swwt_checker.sv @@
// Port-level assertion checker of the segment wait window tuner and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_wait_window_tuner_assert.svh"

module swwt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cmd_valid,
    input wire logic                          cmd_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic [swwt_pkg::STATUS_W-1:0] rsp_status,
    input wire logic                          rsp_has_current,
    input wire logic [swwt_pkg::ID_W-1:0]     rsp_current_segment,
    input wire logic [swwt_pkg::WAIT_W-1:0]   rsp_current_wait
);
    import swwt_pkg::*;

    // An accepted event keeps the block busy for the next cycle.
    `SWWT_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "event accepted back to back")

    // A stalled result beat holds its payload.
    `SWWT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_has_current) && $stable(rsp_current_segment) && $stable(rsp_current_wait), "stalled result changed")

    // With no open segment the id and window read as zero.
    `SWWT_ASSERT_NOW(a_none_zero, rsp_valid && !rsp_has_current, (rsp_current_segment == '0) && (rsp_current_wait == '0), "closed result not zero")

    // A full nesting stack implies an open segment.
    `SWWT_ASSERT_NOW(a_full_open, rsp_valid && (rsp_status == STAT_FULL), rsp_has_current, "stack full without open segment")

endmodule

bind segment_wait_window_tuner swwt_checker u_swwt_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd.valid),
    .cmd_ready           (cmd.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_has_current     (rsp.has_current),
    .rsp_current_segment (rsp.current_segment),
    .rsp_current_wait    (rsp.current_wait)
);

`default_nettype wire
